/* src/int_to_pow2_radix_ascii_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the power-of-two radix ASCII converter
// Shared property shorthands, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef INT_TO_POW2_RADIX_ASCII_CORE_MACROS_SVH
`define INT_TO_POW2_RADIX_ASCII_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/itpr_pkg.sv */
// ----------------------------------------------------------------------------
// itpr_pkg
// Widths, character codes and small digit tables for the radix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itpr_pkg;

  localparam int ValueW = 32;
  localparam int RadixW = 3;
  localparam int CharW  = 8;
  localparam int DigitW = 5;
  localparam int CntW   = 5;
  // Widest digit-aligned field: seven base-32 digits.
  localparam int SrW    = 35;

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharAlpha = 8'h37;  // 'A' minus ten

  // Sequencer request to the output stage.
  typedef struct packed {
    logic              emit;
    logic              minus;
    logic              last;
    logic [DigitW-1:0] digit;
  } out_step_t;

  // Sequencer request to the digit shift register.
  typedef struct packed {
    logic load;
    logic shift;
  } sr_ctrl_t;

  function automatic logic radix_ok(input logic [RadixW-1:0] r);
    radix_ok = (r >= 3'd1) && (r <= 3'd5);
  endfunction

  // Number of digit positions minus one, ceil(32 / r) - 1.
  function automatic logic [CntW-1:0] last_pos(input logic [RadixW-1:0] r);
    unique case (r)
      3'd1:    last_pos = 5'd31;
      3'd2:    last_pos = 5'd15;
      3'd3:    last_pos = 5'd10;
      3'd4:    last_pos = 5'd7;
      3'd5:    last_pos = 5'd6;
      default: last_pos = 5'd0;
    endcase
  endfunction

  // Left padding that puts the top digit at the top of the shift register.
  function automatic logic [1:0] pad_bits(input logic [RadixW-1:0] r);
    unique case (r)
      3'd1:    pad_bits = 2'd3;
      3'd2:    pad_bits = 2'd3;
      3'd3:    pad_bits = 2'd2;
      3'd4:    pad_bits = 2'd3;
      default: pad_bits = 2'd0;
    endcase
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    if (d < 5'd10) begin
      digit_char = CharZero + {3'b000, d};
    end else begin
      digit_char = CharAlpha + {3'b000, d};
    end
  endfunction

endpackage

/* src/itpr_if.sv */
// ----------------------------------------------------------------------------
// itpr channel interfaces
// Valid/ready channels for the integer request and the character results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface itpr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [itpr_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [itpr_pkg::CharW-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* src/itpr_digit_sr.sv */
// ----------------------------------------------------------------------------
// itpr_digit_sr
// Digit-aligned magnitude shift register; presents the top digit each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itpr_digit_sr (
  input  logic                             clk_i,
  input  itpr_pkg::sr_ctrl_t               ctrl_i,
  input  logic [itpr_pkg::RadixW-1:0]      radix_i,
  input  logic [itpr_pkg::ValueW-1:0]      mag_i,
  output logic [itpr_pkg::DigitW-1:0]      digit_o
);

  logic [itpr_pkg::SrW-1:0]    sr_q, sr_d;
  logic [itpr_pkg::DigitW-1:0] win;

  always_comb begin
    sr_d = sr_q;
    if (ctrl_i.load) begin
      sr_d = {3'b000, mag_i} << itpr_pkg::pad_bits(radix_i);
    end else if (ctrl_i.shift) begin
      sr_d = sr_q << radix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign win = sr_q[itpr_pkg::SrW-1 -: itpr_pkg::DigitW];

  always_comb begin
    unique case (radix_i)
      3'd1:    digit_o = {4'b0000, win[4]};
      3'd2:    digit_o = {3'b000, win[4:3]};
      3'd3:    digit_o = {2'b00, win[4:2]};
      3'd4:    digit_o = {1'b0, win[4:1]};
      3'd5:    digit_o = win;
      default: digit_o = '0;
    endcase
  end

endmodule

/* src/itpr_out_stage.sv */
// ----------------------------------------------------------------------------
// itpr_out_stage
// Character encoder and output register for the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itpr_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itpr_pkg::out_step_t  step_i,
  output logic                 free_o,
  itpr_out_if.source           out_o
);

  logic                       valid_q, valid_d;
  logic [itpr_pkg::CharW-1:0] char_q, char_d;
  logic                       last_q, last_d;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (step_i.emit) begin
      valid_d = 1'b1;
      char_d  = step_i.minus ? itpr_pkg::CharMinus : itpr_pkg::digit_char(step_i.digit);
      last_d  = step_i.last;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

endmodule

/* src/int_to_pow2_radix_ascii_core.sv */
// ----------------------------------------------------------------------------
// int_to_pow2_radix_ascii_core
// Signed 32-bit integer to ASCII text in base 2^r, one number per request.
// ----------------------------------------------------------------------------
// Converts one signed integer per input request into characters in base 2^r
// (r = radix_log2, 1 to 5), most significant digit first, with no leading
// zeros, a leading '-' for negative numbers and '0' for zero; last_char marks
// the final character. The magnitude is loaded in the accept cycle and the
// digit shift register then moves one digit position per cycle, dropping
// leading zero digits and emitting the rest; it holds while the minus sign
// goes out and while a digit waits on a stalled output. A nonzero value
// with radix_log2 outside 1 to 5 yields no characters, and the block stays
// ready for the next number. The next number is taken once the last
// character is in the output register. Write radix_log2 only while no
// conversion is in progress.
`timescale 1ns / 1ps

module int_to_pow2_radix_ascii_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itpr_pkg::RadixW-1:0]   cfg_data_i,
  itpr_in_if.sink                       in_i,
  itpr_out_if.source                    out_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic                          state_q, state_d;
  logic                          neg_q, neg_d;
  logic                          started_q, started_d;
  logic [itpr_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [itpr_pkg::RadixW-1:0]   radix_q;

  logic                          in_fire, go, out_free;
  logic                          skip, emit_minus, emit_dig;
  logic [itpr_pkg::ValueW-1:0]   mag;
  logic [itpr_pkg::DigitW-1:0]   digit;
  itpr_pkg::sr_ctrl_t            sr_ctrl;
  itpr_pkg::out_step_t           step;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign mag        = in_i.value[itpr_pkg::ValueW-1] ? (~in_i.value + 32'd1) : in_i.value;
  // Zero converts whatever the radix; other values need a legal radix.
  assign go         = in_fire && ((in_i.value == '0) || itpr_pkg::radix_ok(radix_q));

  // A leading zero digit is dropped without waiting for the output side.
  assign skip       = (state_q == StBusy) && !neg_q && !started_q &&
                      (digit == '0) && (cnt_q != '0);
  assign emit_minus = (state_q == StBusy) && neg_q && out_free;
  assign emit_dig   = (state_q == StBusy) && !neg_q && !skip && out_free;

  assign sr_ctrl.load  = go;
  assign sr_ctrl.shift = skip || emit_dig;

  assign step.emit  = emit_minus || emit_dig;
  assign step.minus = emit_minus;
  assign step.last  = emit_dig && (cnt_q == '0);
  assign step.digit = digit;

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    started_d = started_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (go) begin
          state_d   = StBusy;
          neg_d     = in_i.value[itpr_pkg::ValueW-1];
          started_d = 1'b0;
          cnt_d     = (in_i.value == '0) ? '0 : itpr_pkg::last_pos(radix_q);
        end
      end
      StBusy: begin
        if (emit_minus) begin
          neg_d = 1'b0;
        end
        if (skip || emit_dig) begin
          cnt_d = cnt_q - 5'd1;
        end
        if (emit_dig) begin
          started_d = 1'b1;
          if (cnt_q == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      radix_q   <= 3'd4;
    end else begin
      state_q   <= state_d;
      neg_q     <= neg_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      if (cfg_we_i) begin
        radix_q <= cfg_data_i;
      end
    end
  end

  itpr_digit_sr u_digit_sr (
    .clk_i   (clk_i),
    .ctrl_i  (sr_ctrl),
    .radix_i (radix_q),
    .mag_i   (mag),
    .digit_o (digit)
  );

  itpr_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

/* src/itpr_checker.sv */
// ----------------------------------------------------------------------------
// itpr_checker
// Port-level checks on the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "int_to_pow2_radix_ascii_core_macros.svh"

module itpr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic signed [itpr_pkg::ValueW-1:0] in_value_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [itpr_pkg::CharW-1:0]         out_char_i,
  input logic                               out_last_i
);

  // A stalled character must not change.
  `ITPR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(out_last_i), "stalled character changed")

  // Zero always produces a character, so the block must be busy afterwards.
  `ITPR_ASSERT_NEXT(a_zero_busy, in_valid_i && in_ready_i && (in_value_i == '0), !in_ready_i, "zero request did not start a conversion")

  // A minus sign is never the final character.
  `ITPR_ASSERT_SAME(a_minus_not_last, out_valid_i && (out_char_i == itpr_pkg::CharMinus), !out_last_i, "minus sign flagged as last")

  // A delivered minus sign is followed by digits, never another sign.
  `ITPR_ASSERT_NEXT(a_minus_once, out_valid_i && out_ready_i && (out_char_i == itpr_pkg::CharMinus), !(out_valid_i && (out_char_i == itpr_pkg::CharMinus)), "two minus signs in a row")

endmodule

bind int_to_pow2_radix_ascii_core itpr_checker u_itpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_value_i  (in_i.value),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last_char)
);
